[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Every macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mak_pkg.sv]
// ---------------------------------------------------------------------------
// mak_pkg
// Types, codes and reset values of the master attach and keepalive block.
// ---------------------------------------------------------------------------
package mak_pkg;

	localparam int AddrW    = 16;
	localparam int CodeW    = 8;
	localparam int WinW     = 8;
	localparam int MissW    = 4;
	localparam int KindW    = 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// Byte-padded stream payload widths.
	localparam int InDataW  = 24;
	localparam int OutDataW = 40;

	// Kinds of packet the node asks to send.
	localparam logic [KindW-1:0] KIND_NONE     = 2'd0;
	localparam logic [KindW-1:0] KIND_ANNOUNCE = 2'd1;
	localparam logic [KindW-1:0] KIND_ROUTES   = 2'd2;
	localparam logic [KindW-1:0] KIND_PONG     = 2'd3;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_WINDOW_TICKS     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CODE_IM_MASTER   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CODE_PING        = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CODE_PING_ROUTES = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ANNOUNCE_ADDR    = 3'd5;

	// Register reset values.
	localparam logic [WinW-1:0]  RST_WINDOW_TICKS     = 8'd10;
	localparam logic [MissW-1:0] RST_RETRY_LIMIT      = 4'd3;
	localparam logic [CodeW-1:0] RST_CODE_IM_MASTER   = 8'd1;
	localparam logic [CodeW-1:0] RST_CODE_PING        = 8'd2;
	localparam logic [CodeW-1:0] RST_CODE_PING_ROUTES = 8'd3;
	localparam logic [AddrW-1:0] RST_ANNOUNCE_ADDR    = 16'hffff;

	// Command codes of an input transaction.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	typedef struct packed {
		logic [WinW-1:0]  window_ticks;
		logic [MissW-1:0] retry_limit;
		logic [CodeW-1:0] code_im_master;
		logic [CodeW-1:0] code_ping;
		logic [CodeW-1:0] code_ping_routes;
		logic [AddrW-1:0] announce_addr;
	} cfg_t;

	typedef struct packed {
		logic [KindW-1:0] send_kind;
		logic [AddrW-1:0] dest_address;
		logic             master_known;
		logic [AddrW-1:0] master_now;
	} result_t;

endpackage

[hw/rtl/mak_core.sv]
// ---------------------------------------------------------------------------
// mak_core
// Attach and keepalive state with its next-state logic. The state moves on
// when step is high; result describes that step.
// ---------------------------------------------------------------------------
module mak_core
	import mak_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             command,
	input  logic [AddrW-1:0] src_address,
	input  logic [CodeW-1:0] packet_type,
	input  cfg_t             cfg,
	output result_t          result
);

	logic [AddrW-1:0] master_q;
	logic             pending_q;
	logic [WinW-1:0]  win_q;
	logic [MissW-1:0] miss_q;

	logic [AddrW-1:0] master_d;
	logic             pending_d;
	logic [WinW-1:0]  win_d;
	logic [MissW-1:0] miss_d;

	logic [WinW-1:0]  wlen;
	logic [MissW-1:0] rlim;
	logic [WinW-1:0]  win_inc;
	logic [MissW-1:0] miss_inc;
	logic             announce;
	logic [KindW-1:0] kind;
	logic [AddrW-1:0] dest;

	// A zero window length or retry limit behaves like one.
	assign wlen     = (cfg.window_ticks == '0) ? WinW'(1) : cfg.window_ticks;
	assign rlim     = (cfg.retry_limit == '0) ? MissW'(1) : cfg.retry_limit;
	assign win_inc  = win_q + WinW'(1);
	assign miss_inc = miss_q + MissW'(1);

	always_comb begin
		master_d  = master_q;
		pending_d = pending_q;
		win_d     = win_q;
		miss_d    = miss_q;
		announce  = 1'b0;
		kind      = KIND_NONE;
		dest      = '0;
		if (master_q == '0 && pending_q) begin
			announce = 1'b1;
		end else if (master_q == '0) begin
			if (command == CMD_TICK) begin
				win_d = win_inc;
				if (win_inc >= wlen) begin
					announce = 1'b1;
				end
			end else if (packet_type == cfg.code_im_master) begin
				if (src_address != '0) begin
					master_d = src_address;
					kind     = KIND_ROUTES;
					dest     = src_address;
					win_d    = '0;
					miss_d   = '0;
				end else begin
					announce = 1'b1;
				end
			end
		end else begin
			if (command == CMD_TICK) begin
				win_d = win_inc;
				if (win_inc >= wlen) begin
					win_d  = '0;
					miss_d = miss_inc;
					if (miss_inc >= rlim) begin
						master_d = '0;
						announce = 1'b1;
					end
				end
			end else if (src_address == master_q) begin
				// A plain ping wins when both ping codes are the same.
				if (packet_type == cfg.code_ping) begin
					kind   = KIND_PONG;
					dest   = src_address;
					win_d  = '0;
					miss_d = '0;
				end else if (packet_type == cfg.code_ping_routes) begin
					win_d  = '0;
					miss_d = '0;
				end
			end
		end
		if (announce) begin
			kind      = KIND_ANNOUNCE;
			dest      = cfg.announce_addr;
			win_d     = '0;
			miss_d    = '0;
			pending_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q  <= '0;
			pending_q <= 1'b1;
			win_q     <= '0;
			miss_q    <= '0;
		end else if (step) begin
			master_q  <= master_d;
			pending_q <= pending_d;
			win_q     <= win_d;
			miss_q    <= miss_d;
		end
	end

	assign result.send_kind    = kind;
	assign result.dest_address = dest;
	assign result.master_known = (master_d != '0);
	assign result.master_now   = master_d;

endmodule

[hw/rtl/master_attach_keepalive_fsm_top.sv]
// ---------------------------------------------------------------------------
// master_attach_keepalive_fsm_top
// Node-side attach and keepalive machine: ticks and received frames in, one
// send request with the current master status out for every input.
// ---------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                  | tuser
//  ---------+-----------+-------------------------------------+-----------
//  s_axis   | in        | src_address[15:0], packet_type[7:0] | command
//  m_axis   | out       | dest_address, master_known,         | send_kind
//           |           | master_now, 7 zero bits             |
//  cfg      | in        | write enable, index, 16-bit data    | -
//
// One transaction enters per cycle while s_tready is high. It is held in
// an input register, goes through the next-state logic and moves to the
// result register once that is empty or being read, then is offered on m_axis.
// s_tready drops only while both registers are full and m_tready is low.
// Reset clears the attach state; the first input after reset sends the
// announce. Configuration registers reset to their documented defaults.
// ---------------------------------------------------------------------------
module master_attach_keepalive_fsm_top
	import mak_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // src_address[15:0], packet_type[23:16]
	input  logic                s_tuser,   // command[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // dest[15:0], known[16], now[32:17], 0
	output logic [KindW-1:0]    m_tuser,   // send_kind[1:0]
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

`include "assert_macros.svh"

	cfg_t cfg_q;

	logic             valid_s1;
	logic             command_s1;
	logic [AddrW-1:0] src_s1;
	logic [CodeW-1:0] ptype_s1;

	logic    out_valid_q;
	result_t out_q;
	result_t result;
	logic    advance;
	logic    step;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ticks     <= RST_WINDOW_TICKS;
			cfg_q.retry_limit      <= RST_RETRY_LIMIT;
			cfg_q.code_im_master   <= RST_CODE_IM_MASTER;
			cfg_q.code_ping        <= RST_CODE_PING;
			cfg_q.code_ping_routes <= RST_CODE_PING_ROUTES;
			cfg_q.announce_addr    <= RST_ANNOUNCE_ADDR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_TICKS:     cfg_q.window_ticks     <= cfg_data[WinW-1:0];
				REG_RETRY_LIMIT:      cfg_q.retry_limit      <= cfg_data[MissW-1:0];
				REG_CODE_IM_MASTER:   cfg_q.code_im_master   <= cfg_data[CodeW-1:0];
				REG_CODE_PING:        cfg_q.code_ping        <= cfg_data[CodeW-1:0];
				REG_CODE_PING_ROUTES: cfg_q.code_ping_routes <= cfg_data[CodeW-1:0];
				REG_ANNOUNCE_ADDR:    cfg_q.announce_addr    <= cfg_data[AddrW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tuser;
			src_s1     <= s_tdata[AddrW-1:0];
			ptype_s1   <= s_tdata[AddrW+CodeW-1:AddrW];
		end
		if (step) begin
			out_q <= result;
		end
	end

	mak_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.command     (command_s1),
		.src_address (src_s1),
		.packet_type (ptype_s1),
		.cfg         (cfg_q),
		.result      (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.send_kind;
	assign m_tdata  = {(OutDataW - 2*AddrW - 1)'(0), out_q.master_now,
		out_q.master_known, out_q.dest_address};

	// A result that sends nothing carries no destination.
	`ASSERT_IMPLY(a_none_no_dest, m_tvalid && m_tuser == KIND_NONE,
		m_tdata[AddrW-1:0] == '0, "send of kind none has a destination")
	// The master flag always agrees with the master address.
	`ASSERT_IMPLY(a_known_matches, m_tvalid,
		m_tdata[AddrW] == (out_q.master_now != '0), "master flag disagrees with address")
	// Pongs and route reports are addressed to the attached master.
	`ASSERT_IMPLY(a_reply_to_master,
		m_tvalid && (m_tuser == KIND_PONG || m_tuser == KIND_ROUTES),
		out_q.dest_address == out_q.master_now && out_q.master_now != '0,
		"reply not addressed to the master")
	// Input stalls only when both stages are full and the output is held.
	`ASSERT_IMPLY(a_stall_cause, !s_tready,
		valid_s1 && out_valid_q && !m_tready, "input stalled without backpressure")

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the master attach and keepalive block. A queue of
// ticks and received frames feeds a stream driver, and a clocked predictor
// works out the send request and master status for every accepted
// transaction. A monitor compares each result field by field. The run steps
// through several register settings and sender and receiver idling mixes.
// ---------------------------------------------------------------------------
module tb
	import mak_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic             cmd;
		logic [AddrW-1:0] src;
		logic [CodeW-1:0] ptype;
	} rx_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic [KindW-1:0]    m_tuser;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// Stimulus waiting for the driver, and status results still to come back.
	rx_item_t rx_pending[$];
	result_t  status_due[$];
	rx_item_t on_wire;

	// Predictor copy of the registers and of the attach state.
	cfg_t             node_cfg;
	logic [AddrW-1:0] sh_master;
	logic             sh_announce;
	logic [WinW-1:0]  sh_win;
	logic [MissW-1:0] sh_miss;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int n_checked = 0;
	int n_settings = 1;
	int kind_seen[4] = '{0, 0, 0, 0};

	master_attach_keepalive_fsm_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic void send_announce(ref result_t r);
		r.send_kind = KIND_ANNOUNCE;
		r.dest_address = node_cfg.announce_addr;
		sh_win = '0;
		sh_miss = '0;
		sh_announce = 1'b0;
	endfunction

	// Advances the attach state by one transaction and returns the status it yields.
	function automatic result_t next_node_status(input rx_item_t it);
		result_t r;
		logic [WinW-1:0] wlen;
		logic [MissW-1:0] rlim;
		r = '0;
		r.send_kind = KIND_NONE;
		wlen = (node_cfg.window_ticks == '0) ? WinW'(1) : node_cfg.window_ticks;
		rlim = (node_cfg.retry_limit == '0) ? MissW'(1) : node_cfg.retry_limit;
		if (sh_master == '0 && sh_announce) begin
			send_announce(r);
		end else if (sh_master == '0) begin
			if (it.cmd == CMD_TICK) begin
				sh_win = sh_win + 1'b1;
				if (sh_win >= wlen) begin
					send_announce(r);
				end
			end else if (it.ptype == node_cfg.code_im_master) begin
				if (it.src != '0) begin
					sh_master = it.src;
					r.send_kind = KIND_ROUTES;
					r.dest_address = it.src;
					sh_win = '0;
					sh_miss = '0;
				end else begin
					send_announce(r);
				end
			end
		end else begin
			if (it.cmd == CMD_TICK) begin
				sh_win = sh_win + 1'b1;
				if (sh_win >= wlen) begin
					sh_win = '0;
					sh_miss = sh_miss + 1'b1;
					if (sh_miss >= rlim) begin
						sh_master = '0;
						send_announce(r);
					end
				end
			end else if (it.src == sh_master) begin
				// A plain ping wins when both ping codes are the same.
				if (it.ptype == node_cfg.code_ping) begin
					r.send_kind = KIND_PONG;
					r.dest_address = it.src;
					sh_win = '0;
					sh_miss = '0;
				end else if (it.ptype == node_cfg.code_ping_routes) begin
					sh_win = '0;
					sh_miss = '0;
				end
			end
		end
		r.master_known = (sh_master != '0);
		r.master_now = sh_master;
		return r;
	endfunction

	// Driver: the predictor runs on every accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				status_due.push_back(next_node_status(on_wire));
			end
			if (!s_tvalid || s_tready) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = rx_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_wire.ptype, on_wire.src};
					s_tuser <= on_wire.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure and the field-by-field check.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					flag_mismatch("result with no transaction outstanding");
				end else begin
					want = status_due.pop_front();
					n_checked++;
					kind_seen[want.send_kind]++;
					if (m_tuser != want.send_kind)
						flag_mismatch($sformatf("send_kind %0d, expected %0d",
							m_tuser, want.send_kind));
					if (m_tdata[15:0] != want.dest_address)
						flag_mismatch($sformatf("dest_address %h, expected %h",
							m_tdata[15:0], want.dest_address));
					if (m_tdata[16] != want.master_known)
						flag_mismatch($sformatf("master_known %b, expected %b",
							m_tdata[16], want.master_known));
					if (m_tdata[32:17] != want.master_now)
						flag_mismatch($sformatf("master_now %h, expected %h",
							m_tdata[32:17], want.master_now));
					if (m_tdata[39:33] != '0)
						flag_mismatch($sformatf("padding bits %b not zero", m_tdata[39:33]));
				end
			end
		end
	end

	task automatic push_item(input logic cmd, input logic [AddrW-1:0] src,
			input logic [CodeW-1:0] ptype);
		rx_item_t it;
		it.cmd = cmd;
		it.src = src;
		it.ptype = ptype;
		rx_pending.push_back(it);
	endtask

	task automatic wait_drained();
		while (rx_pending.size() != 0 || s_tvalid || status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all six registers; the block is idle whenever this is called.
	task automatic apply_setting(input logic [WinW-1:0] wt, input logic [MissW-1:0] rl,
			input logic [CodeW-1:0] im, input logic [CodeW-1:0] pg,
			input logic [CodeW-1:0] pr, input logic [AddrW-1:0] bc);
		logic [15:0] junk;
		junk = 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WINDOW_TICKS;
		cfg_data <= {junk[15:8], wt};
		@(posedge clk);
		cfg_index <= REG_RETRY_LIMIT;
		cfg_data <= {junk[15:4], rl};
		@(posedge clk);
		cfg_index <= REG_CODE_IM_MASTER;
		cfg_data <= {junk[7:0], im};
		@(posedge clk);
		cfg_index <= REG_CODE_PING;
		cfg_data <= {junk[11:4], pg};
		@(posedge clk);
		cfg_index <= REG_CODE_PING_ROUTES;
		cfg_data <= {junk[15:8], pr};
		@(posedge clk);
		cfg_index <= REG_ANNOUNCE_ADDR;
		cfg_data <= bc;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_cfg.window_ticks = wt;
		node_cfg.retry_limit = rl;
		node_cfg.code_im_master = im;
		node_cfg.code_ping = pg;
		node_cfg.code_ping_routes = pr;
		node_cfg.announce_addr = bc;
		n_settings++;
	endtask

	// Mostly well-formed attach and keepalive traffic. A rough guess of the
	// attached master steers pings toward the right source.
	task automatic queue_traffic(input int target);
		int made;
		int pick;
		int burst;
		int wl;
		int rl;
		int g_ticks;
		int g_miss;
		logic [AddrW-1:0] g_master;
		logic [AddrW-1:0] peer;
		wl = (node_cfg.window_ticks == 0) ? 1 : int'(node_cfg.window_ticks);
		rl = (node_cfg.retry_limit == 0) ? 1 : int'(node_cfg.retry_limit);
		g_master = sh_master;
		g_ticks = int'(sh_win);
		g_miss = int'(sh_miss);
		made = 0;
		while (made < target) begin
			pick = $urandom_range(99);
			burst = 0;
			if (pick < 30)
				burst = 1;
			else if (pick < 38)
				burst = $urandom_range(1, wl + 2);
			if (burst != 0) begin
				repeat (burst) begin
					push_item(CMD_TICK, AddrW'($urandom), CodeW'($urandom));
					g_ticks++;
					if (g_ticks >= wl) begin
						g_ticks = 0;
						if (g_master != '0) begin
							g_miss++;
							if (g_miss >= rl) begin
								g_master = '0;
								g_miss = 0;
							end
						end
					end
				end
				made += burst;
			end else begin
				if (pick < 50) begin
					peer = ($urandom_range(7) == 0) ? '0 : AddrW'($urandom);
					push_item(CMD_FRAME, peer, node_cfg.code_im_master);
					if (g_master == '0) begin
						g_master = peer;
						g_ticks = 0;
						g_miss = 0;
					end
				end else if (pick < 78) begin
					push_item(CMD_FRAME, g_master,
						(pick < 68) ? node_cfg.code_ping : node_cfg.code_ping_routes);
					g_ticks = 0;
					g_miss = 0;
				end else if (pick < 86) begin
					push_item(CMD_FRAME, g_master, CodeW'($urandom));
				end else begin
					push_item(CMD_FRAME, AddrW'($urandom), CodeW'($urandom));
				end
				made++;
			end
		end
	endtask

	initial begin
		int send_plan[8];
		int stall_plan[8];
		send_plan = '{0, 66, 0, 37, 0, 66, 0, 37};
		stall_plan = '{0, 0, 66, 37, 0, 0, 66, 37};
		node_cfg.window_ticks = RST_WINDOW_TICKS;
		node_cfg.retry_limit = RST_RETRY_LIMIT;
		node_cfg.code_im_master = RST_CODE_IM_MASTER;
		node_cfg.code_ping = RST_CODE_PING;
		node_cfg.code_ping_routes = RST_CODE_PING_ROUTES;
		node_cfg.announce_addr = RST_ANNOUNCE_ADDR;
		sh_master = '0;
		sh_announce = 1'b1;
		sh_win = '0;
		sh_miss = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset settings. The first transaction only
		// announces; im-master from source zero announces again.
		push_item(CMD_TICK, 16'hffff, 8'hff);
		push_item(CMD_FRAME, 16'h0000, RST_CODE_IM_MASTER);
		push_item(CMD_FRAME, 16'h0005, 8'h55);
		push_item(CMD_FRAME, 16'h0007, 8'h00);
		push_item(CMD_FRAME, 16'hffff, RST_CODE_IM_MASTER);
		push_item(CMD_FRAME, 16'h1234, RST_CODE_IM_MASTER);
		push_item(CMD_FRAME, 16'hffff, RST_CODE_PING);
		push_item(CMD_FRAME, 16'hffff, RST_CODE_PING_ROUTES);
		push_item(CMD_FRAME, 16'h0001, RST_CODE_PING);
		push_item(CMD_FRAME, 16'hffff, 8'hff);
		// A full window of ticks with no ping counts one miss.
		repeat (10) push_item(CMD_TICK, 16'h0000, 8'h00);
		push_item(CMD_FRAME, 16'hffff, RST_CODE_PING);
		queue_traffic(100);

		for (int ph = 1; ph < 8; ph++) begin
			wait_drained();
			send_idle_pct = send_plan[ph];
			recv_stall_pct = stall_plan[ph];
			case (ph)
				1: apply_setting(8'd1, 4'd1, 8'd0, 8'd255, 8'd128, 16'h0000);
				2: apply_setting(8'd255, 4'd15, 8'd255, 8'd0, 8'd1, 16'hffff);
				// Both ping codes equal: plain ping takes precedence.
				3: apply_setting(8'd3, 4'd2, 8'd7, 8'd9, 8'd9, AddrW'($urandom));
				// Zero window and zero retry limit behave like one.
				4: apply_setting(8'd0, 4'd0, CodeW'($urandom), CodeW'($urandom),
					CodeW'($urandom), AddrW'($urandom));
				default: apply_setting(WinW'($urandom_range(1, 12)),
					MissW'($urandom_range(1, 4)), CodeW'($urandom), CodeW'($urandom),
					CodeW'($urandom), AddrW'($urandom));
			endcase
			queue_traffic(100);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d transactions checked under %0d register settings:", n_checked,
			n_settings);
		$display("  %0d announces, %0d route reports, %0d pongs, %0d with no send.",
			kind_seen[KIND_ANNOUNCE], kind_seen[KIND_ROUTES], kind_seen[KIND_PONG],
			kind_seen[KIND_NONE]);
		if (err_count == 0 && status_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
